// ----- rtl/move_to_front_list_core_defines.svh -----
// Assertion macros shared by the move-to-front list checker.
`ifndef MOVE_TO_FRONT_LIST_CORE_DEFINES_SVH
`define MOVE_TO_FRONT_LIST_CORE_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define MTF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("move_to_front_list_core: port check failed");

// Checks a property on every clock edge, reset included.
`define MTF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("move_to_front_list_core: reset check failed");

`endif

// ----- rtl/mtf_pkg.sv -----
// Types, codes and constants of the move-to-front list.
`default_nettype none

package mtf_pkg;

  localparam int MTF_CAPACITY = 16;
  localparam int MTF_VALUE_W  = 32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [1:0]                    action;
    logic signed [MTF_VALUE_W-1:0] value;
    logic [3:0]                    position;
  } mtf_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] found_index;
    logic [4:0] entry_count;
  } mtf_out_t;

  // Load select of one list cell; at most one bit is set.
  typedef struct packed {
    logic take_value;
    logic take_left;
    logic take_right;
  } mtf_cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/mtf_cell.sv -----
// One list cell: holds an entry, compares it with the request value, shifts.
`default_nettype none

module mtf_cell (
  input  wire                          clk,
  input  mtf_pkg::mtf_cell_ctl_t       ctl,
  input  wire [mtf_pkg::MTF_VALUE_W-1:0] value_in,
  input  wire [mtf_pkg::MTF_VALUE_W-1:0] left_in,
  input  wire [mtf_pkg::MTF_VALUE_W-1:0] right_in,
  output logic [mtf_pkg::MTF_VALUE_W-1:0] entry,
  output logic                         match
);
  import mtf_pkg::*;

  logic [MTF_VALUE_W-1:0] entry_r;
  logic [MTF_VALUE_W-1:0] entry_nxt;
  logic                   match_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.take_value) begin
      entry_nxt = value_in;
    end else if (ctl.take_left) begin
      entry_nxt = left_in;
    end else if (ctl.take_right) begin
      entry_nxt = right_in;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= (entry_r == value_in);
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

`default_nettype wire

// ----- rtl/move_to_front_list_core.sv -----
// Top level of the move-to-front self-organizing list.
//
// A request beat is taken on in_data at a rising edge where start is high
// and busy is low. It carries an action (insert at front, delete at a
// 0-based position, or search and move to front), a signed 32-bit value
// and a position. Every request yields exactly one result beat.
// The result beat appears on out_data for one cycle with out_valid high,
// registered at the end of the commit state. The receiver has no way
// to stall it, so it must capture the beat in that cycle.
// busy is high through the compare and commit states after acceptance, so
// a new request is not taken until the last one has been committed. Those
// states come from the cell chain: every cell compares its entry in
// parallel, then the shift and the new count are committed.
// The list lives in a row of CAPACITY cells. Each cell loads from its
// left neighbor, its right neighbor or the request value, so all cells
// of the list shift together.
// Synchronous reset empties the list (count to zero) and drops busy and
// out_valid; the cell contents are not cleared, since only cells below
// the count are ever looked at.
`default_nettype none

module move_to_front_list_core #(
  parameter int CAPACITY = mtf_pkg::MTF_CAPACITY
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  mtf_pkg::mtf_in_t  in_data,
  output logic              out_valid,
  output mtf_pkg::mtf_out_t out_data
);
  import mtf_pkg::*;

  // Width that holds every count from zero up to CAPACITY.
  localparam int CW = $clog2(CAPACITY + 1);
  // Width wide enough for a position, a cell index or a count, for comparing them.
  localparam int PW = CW + 4;

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CMP    = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]    state_r;
  logic [1:0]    state_nxt;
  mtf_in_t       item_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  mtf_out_t      out_r;
  mtf_out_t      out_nxt;

  logic [MTF_VALUE_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]    match;
  logic [CAPACITY-1:0]    live_match;
  logic [CAPACITY-1:0]    ahead;
  logic [CAPACITY-1:0]    first;
  logic [CAPACITY-1:0]    ones;
  logic                   any_hit;
  logic [CW-1:0]          hit_index;
  mtf_cell_ctl_t          ctl [CAPACITY];

  // The sequencer: accept, compare in all cells, commit.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = S_CMP;
      S_CMP:    state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // Match flags of the cells that hold live entries, and the first of them.
  // A cell's ahead flag is set, placing it past the first hit, when any live match lies to its left.
  always_comb begin
    ones      = '1;
    hit_index = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      live_match[i] = match[i] & (CW'(i) < count_r);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      ahead[i] = |(live_match & (ones >> (CAPACITY - i)));
    end
    first   = live_match & ~ahead;
    any_hit = |live_match;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) hit_index = hit_index | CW'(i + 1);
    end
  end

  // Commit: choose each cell's load, the new count and the result beat.
  always_comb begin
    count_nxt           = count_r;
    out_nxt.status      = ST_MISS;
    out_nxt.found_index = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i] = '0;
    end
    if (state_r == S_COMMIT) begin
      unique case (item_r.action)
        ACT_INSERT: begin
          if (count_r == CW'(CAPACITY)) begin
            out_nxt.status = ST_FULL;
          end else begin
            out_nxt.status = ST_OK;
            count_nxt      = count_r + CW'(1);
            ctl[0].take_value = 1'b1;
            for (int i = 1; i < CAPACITY; i++) begin
              ctl[i].take_left = 1'b1;
            end
          end
        end
        ACT_DELETE: begin
          if (PW'(item_r.position) < PW'(count_r)) begin
            out_nxt.status = ST_OK;
            count_nxt      = count_r - CW'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              ctl[i].take_right = (PW'(i) >= PW'(item_r.position));
            end
          end
        end
        ACT_SEARCH: begin
          if (any_hit) begin
            out_nxt.status      = ST_OK;
            out_nxt.found_index = 5'(hit_index);
            ctl[0].take_value   = 1'b1;
            for (int i = 1; i < CAPACITY; i++) begin
              ctl[i].take_left = ~ahead[i];
            end
          end
        end
        default: begin
          out_nxt.status = ST_MISS;
        end
      endcase
    end
    out_nxt.entry_count = 5'(count_nxt);
  end

  // The row of cells; the ends see the request value and their own entry.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    mtf_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[g]),
      .value_in (item_r.value),
      .left_in  ((g == 0) ? item_r.value : entries[(g == 0) ? 0 : g - 1]),
      .right_in ((g == CAPACITY - 1) ? entries[g]
                                     : entries[(g == CAPACITY - 1) ? g : g + 1]),
      .entry    (entries[g]),
      .match    (match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == S_COMMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= in_data;
    end
    if (state_r == S_COMMIT) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/mtf_checker.sv -----
// Port-level checker for the move-to-front list, bound to the top level.
`default_nettype none
`include "move_to_front_list_core_defines.svh"

module mtf_checker #(
  parameter int CAPACITY = mtf_pkg::MTF_CAPACITY
) (
  input wire               clk,
  input wire               rst_n,
  input wire               start,
  input wire               busy,
  input wire               out_valid,
  input mtf_pkg::mtf_out_t out_data
);
  import mtf_pkg::*;

  // An accepted beat keeps the block busy until its result is near.
  `MTF_ASSERT(a_accept_busy, (start && !busy) |=> busy)
  // Results never come in adjacent cycles.
  `MTF_ASSERT(a_no_double, out_valid |=> !out_valid)
  // A found index only comes with a good status.
  `MTF_ASSERT(a_found_ok, (out_valid && out_data.found_index != 5'd0) |->
                          (out_data.status == ST_OK))
  // A full report always shows a list at capacity.
  `MTF_ASSERT(a_full_count, (out_valid && out_data.status == ST_FULL) |->
                            (out_data.entry_count == 5'(CAPACITY)))
  // Reset silences the result strobe.
  `MTF_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid)

endmodule

bind move_to_front_list_core mtf_checker #(.CAPACITY(CAPACITY)) u_mtf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
